// ----- design/wvf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wvf_pkg: shared types and constants of the windowed mode vote filter
// Payload structs, scan token, register indexes and FSM states.
// ----------------------------------------------------------------------------
package wvf_pkg;

  // Counter and bin width; every counter saturates at its all-ones value
  localparam int unsigned CNT_W   = 6;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Bin index width covers the largest supported bin count (64)
  localparam int unsigned BIN_W = 6;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_ROWS    = 2'd0,
    REG_HOLDOFF_LIMIT = 2'd1,
    REG_WINDOW_LIMIT  = 2'd2
  } wvf_reg_e;

  localparam logic [11:0] IMAGE_ROWS_RST    = 12'd480;
  localparam logic [5:0]  HOLDOFF_LIMIT_RST = 6'd12;
  localparam logic [5:0]  WINDOW_LIMIT_RST  = 6'd12;

  // Input transaction
  typedef struct packed {
    logic [3:0]  item_count;
    logic [11:0] box_height;
    logic        present;
  } wvf_in_t;

  // Output transaction
  typedef struct packed {
    logic       accepted;
    logic       vote_valid;
    logic [3:0] voted_count;
  } wvf_out_t;

  // Running maximum handed from cell to cell during a vote
  typedef struct packed {
    logic             vld;
    logic [CNT_W-1:0] freq;
    logic [BIN_W-1:0] idx;
  } wvf_scan_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SCAN = 2'd1,
    ST_EMIT = 2'd2
  } wvf_state_e;

endpackage

// ----- design/wvf_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wvf_cell: one histogram bin of the vote chain
// Holds a saturating bin counter and passes the running maximum on to the
// next cell, replacing it when its own bin is strictly larger.
// ----------------------------------------------------------------------------
module wvf_cell
  import wvf_pkg::*;
#(
  parameter int unsigned CELL_IDX = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             inc_i,
  input  logic [BIN_W-1:0] bin_sel_i,
  input  logic             clr_i,
  input  wvf_scan_t        scan_i,
  output wvf_scan_t        scan_o
);

  logic [CNT_W-1:0] bin_q, bin_d;
  logic             scan_vld_q;
  logic [CNT_W-1:0] scan_freq_q, scan_freq_d;
  logic [BIN_W-1:0] scan_idx_q, scan_idx_d;
  logic             hit;

  // Bin update: clear after a vote, else saturating increment on a hit
  assign hit = inc_i && (bin_sel_i == BIN_W'(CELL_IDX));

  always_comb begin
    bin_d = bin_q;
    if (clr_i) begin
      bin_d = '0;
    end else if (hit && (bin_q != CNT_MAX)) begin
      bin_d = bin_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_q <= '0;
    end else begin
      bin_q <= bin_d;
    end
  end

  // Take over the maximum only when strictly larger, so ties keep the lower bin
  always_comb begin
    scan_freq_d = scan_i.freq;
    scan_idx_d  = scan_i.idx;
    if (bin_q > scan_i.freq) begin
      scan_freq_d = bin_q;
      scan_idx_d  = BIN_W'(CELL_IDX);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_vld_q <= 1'b0;
    end else begin
      scan_vld_q <= scan_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_freq_q <= scan_freq_d;
    scan_idx_q  <= scan_idx_d;
  end

  assign scan_o.vld  = scan_vld_q;
  assign scan_o.freq = scan_freq_q;
  assign scan_o.idx  = scan_idx_q;

endmodule

// ----- design/windowed_mode_vote_filter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_mode_vote_filter: per-frame count histogram with mode vote
// Gates frames on height, hold-off and presence, bins qualifying counts and
// votes the most frequent count when the window completes.
// ----------------------------------------------------------------------------
// One transaction per frame, one result per transaction. A frame that does
// not close a window goes straight to the EMIT state, which loads the result
// once the output register is free. A frame that closes a window passes SCAN
// first: the vote walks a running maximum down the row of COUNT_BINS bin
// cells, one cell per cycle, then clears the bins. The input is stalled while
// a frame is in work; the next frame is taken while the previous result still
// waits in the output register.
// ----------------------------------------------------------------------------
module windowed_mode_vote_filter
  import wvf_pkg::*;
#(
  parameter int unsigned COUNT_BINS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  wvf_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output wvf_out_t              out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  wvf_state_e state_q, state_d;

  logic [11:0]      image_rows_q;
  logic [5:0]       holdoff_limit_q;
  logic [5:0]       window_limit_q;
  logic [CNT_W-1:0] holdoff_q, holdoff_d;
  logic [CNT_W-1:0] sample_q, sample_d;

  logic             in_fire;
  logic             qualify;
  logic             vote;
  logic [BIN_W-1:0] bin_sel;
  logic             launch_q;
  logic             scan_done;
  logic             clr_bins;
  logic             res_load;

  logic             res_acc_q;
  logic             res_vote_q;
  logic [3:0]       res_voted_q;

  logic             out_valid_q;
  wvf_out_t         out_q;

  wvf_scan_t        chain [COUNT_BINS+1];

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_rows_q    <= IMAGE_ROWS_RST;
      holdoff_limit_q <= HOLDOFF_LIMIT_RST;
      window_limit_q  <= WINDOW_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_IMAGE_ROWS:    image_rows_q    <= cfg_data_i;
        REG_HOLDOFF_LIMIT: holdoff_limit_q <= cfg_data_i[5:0];
        REG_WINDOW_LIMIT:  window_limit_q  <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  // Frame gate and window check
  assign in_fire = in_valid_i && !in_stall_o;
  assign qualify = (in_data_i.box_height > {1'b0, image_rows_q[11:1]}) &&
                   (holdoff_q > holdoff_limit_q) && in_data_i.present;
  assign vote    = qualify && (sample_q > window_limit_q);

  // Clamp the count to the last bin
  always_comb begin
    if ({3'b000, in_data_i.item_count} >= 7'(COUNT_BINS)) begin
      bin_sel = BIN_W'(COUNT_BINS - 1);
    end else begin
      bin_sel = {2'b00, in_data_i.item_count};
    end
  end

  // Hold-off and sample counters
  always_comb begin
    holdoff_d = holdoff_q;
    sample_d  = sample_q;
    if (in_fire) begin
      if (vote) begin
        holdoff_d = '0;
        sample_d  = '0;
      end else if (qualify) begin
        if (sample_q != CNT_MAX) begin
          sample_d = sample_q + 1'b1;
        end
      end else if (holdoff_q != CNT_MAX) begin
        holdoff_d = holdoff_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      holdoff_q <= '0;
      sample_q  <= '0;
    end else begin
      holdoff_q <= holdoff_d;
      sample_q  <= sample_d;
    end
  end

  // Row of bin cells; the scan token enters at cell zero
  assign chain[0].vld  = launch_q;
  assign chain[0].freq = '0;
  assign chain[0].idx  = '0;

  for (genvar g = 0; g < COUNT_BINS; g++) begin : g_cell
    wvf_cell #(
      .CELL_IDX (g)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .inc_i     (in_fire && qualify),
      .bin_sel_i (bin_sel),
      .clr_i     (clr_bins),
      .scan_i    (chain[g]),
      .scan_o    (chain[g+1])
    );
  end

  assign scan_done = (state_q == ST_SCAN) && chain[COUNT_BINS].vld;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = vote ? ST_SCAN : ST_EMIT;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (res_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_stall_o = 1'b1;
    clr_bins   = 1'b0;
    res_load   = 1'b0;
    unique case (state_q)
      ST_IDLE: in_stall_o = 1'b0;
      ST_SCAN: clr_bins   = scan_done;
      ST_EMIT: res_load   = !out_valid_q || !out_stall_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      launch_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      launch_q <= in_fire && vote;
    end
  end

  // Hold the pending result of the frame in work
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_acc_q   <= qualify;
      res_vote_q  <= vote;
      res_voted_q <= '0;
    end else if (scan_done) begin
      res_voted_q <= chain[COUNT_BINS].idx[3:0];
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_q.accepted    <= res_acc_q;
      out_q.vote_valid  <= res_vote_q;
      out_q.voted_count <= res_voted_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- bench/wvf_vote_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wvf_vote_checker: frame result predictor and scoreboard
// Watches the configuration port and both channels of the mode vote filter,
// keeps its own copy of the gate, counters and histogram, and compares each
// result transaction field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module wvf_vote_checker
  import wvf_pkg::*;
#(
  parameter int unsigned COUNT_BINS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  wvf_in_t               in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  wvf_out_t              out_data_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    fail_count_o,
  output int                    outstanding_o
);

  // Shadow registers
  logic [11:0]      image_rows;
  logic [5:0]       holdoff_limit;
  logic [5:0]       window_limit;

  // Shadow filter state
  logic [CNT_W-1:0] holdoff_count;
  logic [CNT_W-1:0] sample_index;
  logic [CNT_W-1:0] count_histogram [COUNT_BINS];

  // Results predicted for accepted frames, oldest first
  wvf_out_t         frame_results_q [$];
  int               fail_count = 0;

  assign fail_count_o = fail_count;

  // Most frequent bin; a later bin wins only on a strictly higher count
  function automatic logic [BIN_W-1:0] window_mode();
    logic [BIN_W-1:0] best;
    logic [CNT_W-1:0] best_freq;
    best      = '0;
    best_freq = count_histogram[0];
    for (int b = 1; b < COUNT_BINS; b++) begin
      if (count_histogram[b] > best_freq) begin
        best_freq = count_histogram[b];
        best      = BIN_W'(b);
      end
    end
    return best;
  endfunction

  // Advance the shadow state by one frame and return its result
  function automatic wvf_out_t filter_frame(input wvf_in_t frame);
    wvf_out_t         res;
    int unsigned      bin;
    logic [BIN_W-1:0] mode_bin;
    res = '0;
    if (frame.box_height > (image_rows >> 1) && holdoff_count > holdoff_limit &&
        frame.present) begin
      // Fold counts past the last bin into it
      bin = (frame.item_count >= COUNT_BINS) ? COUNT_BINS - 1 : frame.item_count;
      res.accepted = 1'b1;
      if (count_histogram[bin] != CNT_MAX) begin
        count_histogram[bin] = count_histogram[bin] + 1'b1;
      end
      if (sample_index > window_limit) begin
        mode_bin        = window_mode();
        res.vote_valid  = 1'b1;
        res.voted_count = mode_bin[3:0];
        holdoff_count   = '0;
        sample_index    = '0;
        foreach (count_histogram[b]) count_histogram[b] = '0;
      end else if (sample_index != CNT_MAX) begin
        sample_index = sample_index + 1'b1;
      end
    end else if (holdoff_count != CNT_MAX) begin
      holdoff_count = holdoff_count + 1'b1;
    end
    return res;
  endfunction

  // Track config, predict on input transactions, compare on output ones
  always @(posedge clk_i or negedge rst_ni) begin
    wvf_out_t want;
    wvf_out_t pred;
    if (!rst_ni) begin
      image_rows    = IMAGE_ROWS_RST;
      holdoff_limit = HOLDOFF_LIMIT_RST;
      window_limit  = WINDOW_LIMIT_RST;
      holdoff_count = '0;
      sample_index  = '0;
      foreach (count_histogram[b]) count_histogram[b] = '0;
      frame_results_q.delete();
      outstanding_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_IMAGE_ROWS: begin
            image_rows = cfg_data_i[11:0];
          end
          REG_HOLDOFF_LIMIT: begin
            holdoff_limit = cfg_data_i[5:0];
          end
          REG_WINDOW_LIMIT: begin
            window_limit = cfg_data_i[5:0];
          end
          default: begin
          end
        endcase
      end

      // Append the prediction at the tail of the queue
      if (in_valid_i && !in_stall_i) begin
        pred            = filter_frame(in_data_i);
        frame_results_q = {frame_results_q, pred};
      end

      if (out_valid_i && !out_stall_i) begin
        if (frame_results_q.size() == 0) begin
          if (fail_count < 10) begin
            $display("%0t: unexpected result: accepted=%0b vote_valid=%0b voted_count=%0d",
                     $realtime, out_data_i.accepted, out_data_i.vote_valid,
                     out_data_i.voted_count);
          end
          fail_count++;
        end else begin
          want = frame_results_q.pop_front();
          if (out_data_i.accepted !== want.accepted ||
              out_data_i.vote_valid !== want.vote_valid ||
              out_data_i.voted_count !== want.voted_count) begin
            if (fail_count < 10) begin
              $display("%0t: mismatch (acc/vote/count) expected %0b/%0b/%0d got %0b/%0b/%0d",
                       $realtime, want.accepted, want.vote_valid, want.voted_count,
                       out_data_i.accepted, out_data_i.vote_valid,
                       out_data_i.voted_count);
            end
            fail_count++;
          end
        end
      end

      outstanding_o <= frame_results_q.size();
    end
  end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the windowed mode vote filter
// Drives directed frames that walk the gate, tie-break and register corners,
// then random phases over several register settings with random idle and
// stall cycles. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  import wvf_pkg::*;

  localparam int unsigned COUNT_BINS = 16;
  // Index with no register behind it; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;
  localparam int IDLE_PCT      = 7;
  localparam int SETTLE_CYCLES = COUNT_BINS + 8;

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  wvf_in_t               in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  wvf_out_t              out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Suppress all idling and stalls while set
  bit                    quiet = 1'b0;
  int                    fail_count;
  int                    outstanding;

  windowed_mode_vote_filter #(
    .COUNT_BINS(COUNT_BINS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  wvf_vote_checker #(
    .COUNT_BINS(COUNT_BINS)
  ) vote_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .outstanding_o(outstanding)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Stall the result channel at random
  always @(posedge clk_i) begin
    out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
  end

  function automatic wvf_in_t frame_of(input int count, input int height, input bit pres);
    wvf_in_t f;
    f.item_count = 4'(count);
    f.box_height = 12'(height);
    f.present    = pres;
    return f;
  endfunction

  // Mostly frames that pass the height and presence gates, counts leaning
  // toward a favorite pair so windows have a clear mode; the rest is noise
  function automatic wvf_in_t random_frame(input logic [11:0] rows, input logic [3:0] favorite);
    wvf_in_t f;
    f.item_count = ($urandom_range(99) < 50) ? favorite + 4'($urandom_range(1)) : 4'($urandom);
    if ($urandom_range(99) < 80) begin
      f.box_height = 12'($urandom_range(4095, (rows >> 1) + 1));
      f.present    = 1'b1;
    end else begin
      f.box_height = 12'($urandom);
      f.present    = 1'($urandom);
    end
    return f;
  endfunction

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // Write all three registers; junk in the unused upper bits of the limits
  task automatic configure(input logic [11:0] rows, input logic [5:0] hold,
                           input logic [5:0] win);
    set_reg(REG_IMAGE_ROWS, rows);
    set_reg(REG_HOLDOFF_LIMIT, {6'($urandom), hold});
    set_reg(REG_WINDOW_LIMIT, {6'($urandom), win});
  endtask

  // Offer one frame after random idle cycles and hold it until accepted
  task automatic send_frame(input wvf_in_t frame);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= frame;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  // Drop valid and wait until every predicted result has been taken
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [11:0] rows, input logic [5:0] hold,
                           input logic [5:0] win, input int frames, input bit calm);
    logic [3:0] favorite;
    configure(rows, hold, win);
    quiet    <= calm;
    favorite = 4'($urandom);
    for (int n = 0; n < frames; n++) begin
      if (n % 20 == 0) favorite = 4'($urandom);
      send_frame(random_frame(rows, favorite));
    end
    settle();
    quiet <= 1'b0;
  endtask

  // Stimulus and verdict
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values: hold-off not yet past its limit, height at the gate edge
    send_frame(frame_of(5, 241, 1'b1));
    send_frame(frame_of(4, 240, 1'b1));
    send_frame(frame_of(15, 4095, 1'b0));
    settle();

    // Zero rows, zero limits; the unmapped index must change nothing
    configure(12'd0, 6'd0, 6'd0);
    set_reg(REG_UNMAPPED, 12'hFFF);
    send_frame(frame_of(0, 0, 1'b1));
    send_frame(frame_of(15, 4095, 1'b1));
    send_frame(frame_of(0, 1, 1'b1));       // tie between 0 and 15 votes 0
    send_frame(frame_of(7, 4095, 1'b0));
    send_frame(frame_of(7, 4095, 1'b1));
    send_frame(frame_of(3, 4095, 1'b1));    // tie between 3 and 7 votes 3
    send_frame(frame_of(15, 1, 1'b1));
    send_frame(frame_of(15, 1, 1'b1));
    send_frame(frame_of(15, 1, 1'b1));      // top count wins
    settle();

    // Widest rows, hold-off of one, five-sample window
    configure(12'd4095, 6'd1, 6'd3);
    send_frame(frame_of(9, 2047, 1'b1));
    send_frame(frame_of(9, 2048, 1'b1));
    send_frame(frame_of(9, 2048, 1'b1));
    send_frame(frame_of(2, 4095, 1'b1));
    send_frame(frame_of(9, 3000, 1'b1));
    send_frame(frame_of(2, 4095, 1'b1));
    send_frame(frame_of(9, 3000, 1'b1));    // clear majority of 9
    settle();

    // Random phases over register settings, extremes among them
    run_phase(12'd480, 6'd12, 6'd12, 80, 1'b0);
    run_phase(12'd1, 6'd0, 6'd0, 60, 1'b0);
    run_phase(12'd4095, 6'd2, 6'd5, 80, 1'b0);
    run_phase(12'd0, 6'd1, 6'd1, 60, 1'b0);
    run_phase(12'd640, 6'd62, 6'd61, 70, 1'b0);
    run_phase(12'd720, 6'd0, 6'd61, 80, 1'b0);
    // Vote never fires, as the sample index cannot pass a window limit of 63
    run_phase(12'd300, 6'd0, 6'd63, 90, 1'b1);
    // No frame can qualify, as the hold-off count cannot pass a limit of 63
    run_phase(12'd200, 6'd63, 6'd3, 40, 1'b0);
    run_phase(12'd1000, 6'd3, 6'd2, 40, 1'b0);

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ----- sim.f -----
design/wvf_pkg.sv
design/wvf_cell.sv
design/windowed_mode_vote_filter.sv
bench/wvf_vote_checker.sv
bench/testbench.sv
